// ----- hw/rtl/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntc_pkg: shared types, type codes and helpers of the numeric type converter
// Holds the collapsed type codes, the status codes and integer bound helpers.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // raw type codes that collapse onto others
  localparam logic [4:0] T_NULL   = 5'd14;
  localparam logic [4:0] T_WCHAR  = 5'd15;
  localparam logic [4:0] T_CHAR   = 5'd16;
  localparam logic [4:0] T_CHAR16 = 5'd17;
  localparam logic [4:0] T_CHAR32 = 5'd18;

  // collapsed type codes
  localparam logic [3:0] C_SCHAR  = 4'd0;
  localparam logic [3:0] C_SHORT  = 4'd1;
  localparam logic [3:0] C_INT    = 4'd2;
  localparam logic [3:0] C_LONG   = 4'd3;
  localparam logic [3:0] C_LLONG  = 4'd4;
  localparam logic [3:0] C_UCHAR  = 4'd5;
  localparam logic [3:0] C_USHORT = 4'd6;
  localparam logic [3:0] C_UINT   = 4'd7;
  localparam logic [3:0] C_ULONG  = 4'd8;
  localparam logic [3:0] C_ULLONG = 4'd9;
  localparam logic [3:0] C_BOOL   = 4'd10;
  localparam logic [3:0] C_FLT    = 4'd11;
  localparam logic [3:0] C_DBL    = 4'd12;
  localparam logic [3:0] C_EXT    = 4'd13;
  localparam logic [3:0] C_NULL   = 4'd14;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_VOID     = 3'd1,
    ST_NULL_DST = 3'd2,
    ST_NZ_NULL  = 3'd3,
    ST_FLT_NULL = 3'd4,
    ST_SAT      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FIN  = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } cls_t;

  // unpacked float: value = sig * 2^(e-63) when finite
  typedef struct packed {
    logic               neg;
    cls_t               cls;
    logic signed [17:0] e;
    logic [63:0]        sig;
  } fnum_t;

  // per-transaction control; done marks a final result
  typedef struct packed {
    logic        done;
    logic [63:0] lo;
    logic [15:0] hi;
    status_t     status;
    logic [3:0]  dt;
  } ctl_t;

  // {valid, collapsed code}
  function automatic logic [4:0] collapse(input logic [4:0] t);
    logic [4:0] r;
    unique case (t)
      T_WCHAR:  r = {1'b1, C_INT};
      T_CHAR:   r = {1'b1, C_SCHAR};
      T_CHAR16: r = {1'b1, C_USHORT};
      T_CHAR32: r = {1'b1, C_UINT};
      default:  r = (t <= T_NULL) ? {1'b1, t[3:0]} : 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] int_mask(input logic [3:0] c);
    logic [63:0] m;
    unique case (c)
      C_SCHAR, C_UCHAR:   m = 64'h0000_0000_0000_00FF;
      C_SHORT, C_USHORT:  m = 64'h0000_0000_0000_FFFF;
      C_INT, C_UINT:      m = 64'h0000_0000_FFFF_FFFF;
      default:            m = '1;
    endcase
    return m;
  endfunction

  function automatic logic int_signed(input logic [3:0] c);
    return c <= C_LLONG;
  endfunction

  function automatic logic [63:0] int_pos_max(input logic [3:0] c);
    return int_signed(c) ? (int_mask(c) >> 1) : int_mask(c);
  endfunction

  function automatic logic [63:0] int_neg_lim(input logic [3:0] c);
    return int_signed(c) ? ((int_mask(c) >> 1) + 64'd1) : 64'd0;
  endfunction

endpackage

// ----- hw/rtl/numeric_type_converter.sv -----
// Throughput: one transaction per cycle unless a stalled output holds the pipe;
//   the five register stages each do a bounded slice (decode, normalize, plan,
//   shift, round/pack).
// A stalled output freezes every stage; the pipe holds its contents in place.
// Reset (rst_n low, synchronous) clears all stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// numeric_type_converter: scalar conversion by implicit conversion rules
// Integer, bool, binary32, binary64 and 80-bit extended conversions with
// round to nearest even, saturation on float to integer and error status.
// ----------------------------------------------------------------------------
module numeric_type_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_source_type,
  input  logic [4:0]  in_dest_type,
  input  logic [63:0] in_value_low,
  input  logic [15:0] in_value_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_low,
  output logic [15:0] out_result_high,
  output logic [2:0]  out_status
);
  import ntc_pkg::*;

  // whole pipe moves together; a bubble at the output frees it
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---- stage 1: decode -----------------------------------------------------
  ctl_t  c1_nxt, c1_r;
  fnum_t f1_nxt, f1_r;
  logic  v1_r;

  ntc_decode u_decode (
    .src_type (in_source_type),
    .dst_type (in_dest_type),
    .val_lo   (in_value_low),
    .val_hi   (in_value_high),
    .ctl      (c1_nxt),
    .fnum     (f1_nxt)
  );

  // ---- stage 2: normalize (leading zero count in six halving steps) --------
  ctl_t        c2_r;
  fnum_t       f2_nxt, f2_r;
  logic        v2_r;
  logic [63:0] nsig;
  logic [5:0]  lz;

  always_comb begin
    nsig = f1_r.sig;
    lz   = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((nsig >> (64 - (1 << k))) == 64'd0) begin
        nsig = nsig << (1 << k);
        lz   = lz | 6'(1 << k);
      end
    end
    f2_nxt = f1_r;
    if (f1_r.cls == CLS_FIN) begin
      f2_nxt.sig = nsig;
      f2_nxt.e   = f1_r.e - $signed({12'd0, lz});
    end
  end

  // ---- stage 3: plan the shift, resolve special values ---------------------
  ctl_t               c3_nxt, c3_r;
  logic [63:0]        sig3_r;
  logic [6:0]         sh3_nxt, sh3_r;
  logic               rnd3_nxt, rnd3_r;
  logic               neg3_r;
  logic [10:0]        eb3_nxt, eb3_r;
  logic               v3_r;
  logic signed [17:0] e3, diff3, shs3, bias3, emin3;
  logic [6:0]         shn3;
  logic               isflt3;

  assign e3     = f2_r.e;
  assign isflt3 = (c2_r.dt == C_FLT);
  assign bias3  = isflt3 ? 18'sd127 : 18'sd1023;
  assign emin3  = isflt3 ? -18'sd126 : -18'sd1022;
  assign shn3   = isflt3 ? 7'd40 : 7'd11;     // 64 - precision
  assign diff3  = emin3 - e3;
  assign shs3   = $signed({11'd0, shn3}) + diff3;

  always_comb begin
    c3_nxt   = c2_r;
    sh3_nxt  = 7'd65;
    rnd3_nxt = 1'b0;
    eb3_nxt  = '0;
    if (!c2_r.done) begin
      c3_nxt.done = 1'b1;
      if (c2_r.dt <= C_ULLONG) begin
        priority if (f2_r.cls == CLS_NAN) begin
          c3_nxt.status = ST_SAT;
        end else if (f2_r.cls == CLS_ZERO) begin
          c3_nxt.lo = '0;
        end else if (f2_r.cls == CLS_INF || e3 >= 18'sd64) begin
          c3_nxt.status = ST_SAT;
          c3_nxt.lo = f2_r.neg ? ((64'd0 - int_neg_lim(c2_r.dt)) & int_mask(c2_r.dt))
                               : int_pos_max(c2_r.dt);
        end else begin
          c3_nxt.done = 1'b0;
          sh3_nxt = (e3 >= 18'sd0) ? 7'(18'sd63 - e3) : 7'd65;
        end
      end else if (c2_r.dt == C_EXT) begin
        unique case (f2_r.cls)
          CLS_ZERO: begin
            c3_nxt.lo = '0;
            c3_nxt.hi = {f2_r.neg, 15'd0};
          end
          CLS_INF: begin
            c3_nxt.lo = 64'h8000_0000_0000_0000;
            c3_nxt.hi = {f2_r.neg, 15'h7FFF};
          end
          CLS_NAN: begin
            c3_nxt.lo = {2'b11, f2_r.sig[61:0]};
            c3_nxt.hi = {f2_r.neg, 15'h7FFF};
          end
          default: begin
            c3_nxt.lo = f2_r.sig;
            c3_nxt.hi = {f2_r.neg, 15'(e3 + 18'sd16383)};
          end
        endcase
      end else begin
        // binary32 / binary64 destination
        priority if (f2_r.cls == CLS_ZERO) begin
          c3_nxt.lo = isflt3 ? {32'd0, f2_r.neg, 31'd0} : {f2_r.neg, 63'd0};
        end else if (f2_r.cls == CLS_NAN) begin
          c3_nxt.lo = isflt3 ? {32'd0, f2_r.neg, 8'hFF, 1'b1, f2_r.sig[61:40]}
                             : {f2_r.neg, 11'h7FF, 1'b1, f2_r.sig[61:11]};
        end else if (f2_r.cls == CLS_INF || e3 > bias3) begin
          c3_nxt.lo = isflt3 ? {32'd0, f2_r.neg, 8'hFF, 23'd0}
                             : {f2_r.neg, 11'h7FF, 52'd0};
        end else if (e3 >= emin3) begin
          c3_nxt.done = 1'b0;
          rnd3_nxt = 1'b1;
          sh3_nxt  = shn3;
          eb3_nxt  = 11'(e3 + bias3 - 18'sd1);
        end else begin
          c3_nxt.done = 1'b0;
          rnd3_nxt = 1'b1;
          sh3_nxt  = (shs3 > 18'sd65) ? 7'd65 : 7'(shs3);
        end
      end
    end
  end

  // ---- stage 4: right shift with guard and sticky --------------------------
  ctl_t         c4_r;
  logic [63:0]  mant4_r;
  logic         inc4_nxt, inc4_r;
  logic         neg4_r;
  logic [10:0]  eb4_r;
  logic         v4_r;
  logic [127:0] x4;

  assign x4       = {sig3_r, 64'd0} >> sh3_r;
  assign inc4_nxt = rnd3_r && x4[63] && ((|x4[62:0]) || x4[64]);

  // ---- stage 5: round, pack, saturate --------------------------------------
  logic [63:0] lo_nxt, out_lo_r;
  logic [15:0] out_hi_r;
  status_t     st_nxt, out_st_r;
  logic [63:0] m5, nlim5, pmax5, imask5;
  logic [30:0] v31;
  logic [62:0] v63;

  assign m5     = mant4_r + {63'd0, inc4_r};
  assign nlim5  = int_neg_lim(c4_r.dt);
  assign pmax5  = int_pos_max(c4_r.dt);
  assign imask5 = int_mask(c4_r.dt);
  assign v31    = {eb4_r[7:0], 23'd0} + m5[30:0];
  assign v63    = {eb4_r, 52'd0} + m5[62:0];

  always_comb begin
    lo_nxt = c4_r.lo;
    st_nxt = c4_r.status;
    if (!c4_r.done) begin
      if (c4_r.dt <= C_ULLONG) begin
        if (neg4_r) begin
          if (m5 > nlim5) begin
            st_nxt = ST_SAT;
            lo_nxt = (64'd0 - nlim5) & imask5;
          end else begin
            lo_nxt = (64'd0 - m5) & imask5;
          end
        end else if (m5 > pmax5) begin
          st_nxt = ST_SAT;
          lo_nxt = pmax5;
        end else begin
          lo_nxt = m5;
        end
      end else if (c4_r.dt == C_FLT) begin
        lo_nxt = {32'd0, neg4_r, v31};
      end else begin
        lo_nxt = {neg4_r, v63};
      end
    end
  end

  // ---- registers -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r     <= c1_nxt;
      f1_r     <= f1_nxt;
      c2_r     <= c1_r;
      f2_r     <= f2_nxt;
      c3_r     <= c3_nxt;
      sig3_r   <= f2_r.sig;
      sh3_r    <= sh3_nxt;
      rnd3_r   <= rnd3_nxt;
      neg3_r   <= f2_r.neg;
      eb3_r    <= eb3_nxt;
      c4_r     <= c3_r;
      mant4_r  <= x4[127:64];
      inc4_r   <= inc4_nxt;
      neg4_r   <= neg3_r;
      eb4_r    <= eb3_r;
      out_lo_r <= lo_nxt;
      out_hi_r <= c4_r.hi;
      out_st_r <= st_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_low  = out_lo_r;
  assign out_result_high = out_hi_r;
  assign out_status      = out_st_r;

`ifndef SYNTHESIS
  // error codes always come with an all-zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_VOID || out_status == ST_NULL_DST ||
                  out_status == ST_NZ_NULL || out_status == ST_FLT_NULL)
    |-> out_result_low == 64'd0 && out_result_high == 16'd0)
    else $error("error status with nonzero result");

  // saturation only arises on integer destinations
  a_sat_hi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |-> out_result_high == 16'd0)
    else $error("saturated result with extended upper bits");

  // a transaction in stage 1 moves on when the pipe advances
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !in_stall |=> v2_r)
    else $error("transaction lost between stage 1 and 2");

  // a stalled output keeps the whole pipe frozen
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && out_valid && out_stall |=> v4_r)
    else $error("stage 4 dropped during output stall");
`endif

endmodule

// ----- hw/rtl/ntc_decode.sv -----
// ----------------------------------------------------------------------------
// ntc_decode: first-stage type decode
// Resolves error, pass-through and integer cases; unpacks the float operand.
// ----------------------------------------------------------------------------
module ntc_decode (
  input  logic [4:0]     src_type,
  input  logic [4:0]     dst_type,
  input  logic [63:0]    val_lo,
  input  logic [15:0]    val_hi,
  output ntc_pkg::ctl_t  ctl,
  output ntc_pkg::fnum_t fnum
);
  import ntc_pkg::*;

  logic [4:0]  sc, dc;
  logic [3:0]  s, d;
  logic [63:0] raw_int, mag, smask;
  logic        neg, bnz;
  fnum_t       fd;
  logic [14:0] xex;

  assign sc = collapse(src_type);
  assign dc = collapse(dst_type);
  assign s  = sc[3:0];
  assign d  = dc[3:0];
  assign bnz = |val_lo[7:0];
  assign smask = int_mask(s);
  assign raw_int = val_lo & smask;
  assign xex = val_hi[14:0];

  always_comb begin
    if (s == C_BOOL) begin
      neg = 1'b0;
      mag = {63'd0, bnz};
    end else begin
      neg = int_signed(s) && ((raw_int & ~(smask >> 1)) != 64'd0);
      mag = neg ? ((64'd0 - raw_int) & smask) : raw_int;
    end
  end

  // float operand unpack
  always_comb begin
    fd = '0;
    unique case (s)
      C_FLT: begin
        fd.neg = val_lo[31];
        fd.sig = {1'b0, val_lo[22:0], 40'd0};
        if (val_lo[30:23] == 8'hFF) begin
          fd.cls = (val_lo[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
        end else if (val_lo[30:23] == 8'd0) begin
          fd.cls = (val_lo[22:0] != 23'd0) ? CLS_FIN : CLS_ZERO;
          fd.e   = -18'sd126;
        end else begin
          fd.cls = CLS_FIN;
          fd.sig[63] = 1'b1;
          fd.e   = $signed({10'd0, val_lo[30:23]}) - 18'sd127;
        end
      end
      C_EXT: begin
        fd.neg = val_hi[15];
        if (xex == 15'd0) begin
          fd.cls = (val_lo != 64'd0) ? CLS_FIN : CLS_ZERO;
          fd.sig = val_lo;
          fd.e   = -18'sd16382;
        end else if (xex == 15'h7FFF) begin
          if (!val_lo[63]) begin
            fd.cls = CLS_NAN;
          end else if (val_lo[62:0] == 63'd0) begin
            fd.cls = CLS_INF;
          end else begin
            fd.cls = CLS_NAN;
            fd.sig = {1'b0, val_lo[62:0]};
          end
        end else if (!val_lo[63]) begin
          fd.cls = CLS_NAN;       // unnormal reads as quiet NaN
        end else begin
          fd.cls = CLS_FIN;
          fd.sig = val_lo;
          fd.e   = $signed({3'd0, xex}) - 18'sd16383;
        end
      end
      default: begin  // binary64
        fd.neg = val_lo[63];
        fd.sig = {1'b0, val_lo[51:0], 11'd0};
        if (val_lo[62:52] == 11'h7FF) begin
          fd.cls = (val_lo[51:0] != 52'd0) ? CLS_NAN : CLS_INF;
        end else if (val_lo[62:52] == 11'd0) begin
          fd.cls = (val_lo[51:0] != 52'd0) ? CLS_FIN : CLS_ZERO;
          fd.e   = -18'sd1022;
        end else begin
          fd.cls = CLS_FIN;
          fd.sig[63] = 1'b1;
          fd.e   = $signed({7'd0, val_lo[62:52]}) - 18'sd1023;
        end
      end
    endcase
  end

  always_comb begin
    ctl.done   = 1'b1;
    ctl.lo     = '0;
    ctl.hi     = '0;
    ctl.status = ST_OK;
    ctl.dt     = d;
    fnum       = '0;
    priority if (!sc[4] || !dc[4]) begin
      ctl.status = ST_VOID;
    end else if (s == C_NULL) begin
      if (d == C_NULL) begin
        ctl.lo = val_lo;
      end else if (d != C_BOOL) begin
        ctl.status = ST_NULL_DST;
      end
    end else if (d == C_NULL) begin
      if (s >= C_FLT) begin
        ctl.status = ST_FLT_NULL;
      end else if ((s == C_BOOL) ? bnz : (raw_int != 64'd0)) begin
        ctl.status = ST_NZ_NULL;
      end
    end else if (s == d && s >= C_FLT) begin
      ctl.lo = (s == C_FLT) ? {32'd0, val_lo[31:0]} : val_lo;
      ctl.hi = (s == C_EXT) ? val_hi : 16'd0;
    end else if (s <= C_BOOL) begin
      if (d == C_BOOL) begin
        ctl.lo = {63'd0, mag != 64'd0};
      end else if (d <= C_ULLONG) begin
        ctl.lo = (neg ? (64'd0 - mag) : mag) & int_mask(d);
      end else begin
        ctl.done  = 1'b0;
        fnum.neg  = neg;
        fnum.cls  = (mag != 64'd0) ? CLS_FIN : CLS_ZERO;
        fnum.e    = 18'sd63;
        fnum.sig  = mag;
      end
    end else begin
      if (d == C_BOOL) begin
        ctl.lo = {63'd0, fd.cls != CLS_ZERO};
      end else begin
        ctl.done = 1'b0;
        fnum     = fd;
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for numeric_type_converter
// Sends directed and random conversions through the valid/stall channels,
// computes each expected result with a local conversion model and compares it
// field by field with the transactions that leave the block, in order.
// ----------------------------------------------------------------------------
module testbench;
  import ntc_pkg::*;

  localparam logic [4:0] T_VOID   = 5'd19;
  localparam logic [63:0] TOP     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PAY     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int WDOG_LIMIT       = 5000;
  localparam int TAIL_CYCLES      = 20;

  localparam int K_ZERO = 0;
  localparam int K_FIN  = 1;
  localparam int K_INF  = 2;
  localparam int K_NAN  = 3;

  typedef struct {
    logic [4:0]  src;
    logic [4:0]  dst;
    logic [63:0] lo;
    logic [15:0] hi;
  } conv_req_t;

  typedef struct {
    logic [63:0] lo;
    logic [15:0] hi;
    status_t     status;
  } conv_res_t;

  // unpacked float, value = sig * 2^(e-63) when finite
  typedef struct {
    logic        neg;
    int          kind;
    int          e;
    logic [63:0] sig;
  } ufloat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_source_type = '0;
  logic [4:0]  in_dest_type = '0;
  logic [63:0] in_value_low = '0;
  logic [15:0] in_value_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_low;
  logic [15:0] out_result_high;
  logic [2:0]  out_status;

  conv_req_t pending_q[$];
  conv_res_t expected_q[$];
  int        errors = 0;
  int        sent = 0;
  int        n_items = 0;
  int        quiet_cycles = 0;
  int        phase;
  int        send_idle_pct;
  int        recv_stall_pct;

  numeric_type_converter i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --
  function automatic logic [63:0] lowmask(input int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic int lzc(input logic [63:0] x);
    int n;
    n = 0;
    while (n < 64 && !x[63]) begin
      x = x << 1;
      n++;
    end
    return n;
  endfunction

  // raw type code to canonical code; -1 for void and unused codes
  function automatic int canon(input logic [4:0] t);
    int r;
    case (t)
      T_WCHAR:  r = C_INT;
      T_CHAR:   r = C_SCHAR;
      T_CHAR16: r = C_USHORT;
      T_CHAR32: r = C_UINT;
      default:  r = (t <= T_NULL) ? int'(t) : -1;
    endcase
    return r;
  endfunction

  function automatic int int_bits(input int c);
    int w;
    case (c)
      C_SCHAR, C_UCHAR:   w = 8;
      C_SHORT, C_USHORT:  w = 16;
      C_INT, C_UINT:      w = 32;
      default:            w = 64;
    endcase
    return w;
  endfunction

  function automatic logic [63:0] rne_shift(input logic [63:0] sig, input int sh);
    logic [63:0] mant, rem, half;
    if (sh <= 0) return sig;
    if (sh > 64) return 64'd0;
    if (sh == 64) return (sig > TOP) ? 64'd1 : 64'd0;
    mant = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && mant[0])) mant++;
    return mant;
  endfunction

  function automatic ufloat_t unpack_float(input int c, input logic [63:0] lo,
                                           input logic [15:0] hi);
    ufloat_t f;
    int fb, eb, bias, lz;
    logic [63:0] frac, ex, s;
    f.e = 0;
    f.sig = '0;
    f.kind = K_FIN;
    if (c == C_EXT) begin
      f.neg = hi[15];
      if (hi[14:0] == 15'd0) begin
        if (lo == 0) begin
          f.kind = K_ZERO;
        end else begin
          // denormals and pseudo-denormals by value
          lz = lzc(lo);
          f.sig = lo << lz;
          f.e = -16382 - lz;
        end
      end else if (hi[14:0] == 15'h7FFF) begin
        if (!lo[63]) f.kind = K_NAN;
        else if ((lo & PAY) == 0) f.kind = K_INF;
        else begin
          f.kind = K_NAN;
          f.sig = lo & PAY;
        end
      end else if (!lo[63]) begin
        f.kind = K_NAN;   // unnormal
      end else begin
        f.sig = lo;
        f.e = int'(hi[14:0]) - 16383;
      end
      return f;
    end
    fb   = (c == C_FLT) ? 23 : 52;
    eb   = (c == C_FLT) ? 8 : 11;
    bias = (c == C_FLT) ? 127 : 1023;
    frac = lo & lowmask(fb);
    ex   = (lo >> fb) & lowmask(eb);
    f.neg = lo[fb + eb];
    if (ex == lowmask(eb)) begin
      f.kind = (frac != 0) ? K_NAN : K_INF;
      f.sig = frac << (63 - fb);
    end else if (ex == 0) begin
      if (frac == 0) begin
        f.kind = K_ZERO;
      end else begin
        s = frac << (63 - fb);
        lz = lzc(s);
        f.sig = s << lz;
        f.e = (1 - bias) - lz;
      end
    end else begin
      f.sig = (frac | (64'd1 << fb)) << (63 - fb);
      f.e = int'(ex) - bias;
    end
    return f;
  endfunction

  function automatic logic [63:0] pack_ieee(input ufloat_t f, input int p, input int eb);
    int bias, emin;
    logic [63:0] sbit, infbits, mant;
    bias = (1 << (eb - 1)) - 1;
    emin = 1 - bias;
    sbit = f.neg ? (64'd1 << (p - 1 + eb)) : 64'd0;
    infbits = lowmask(eb) << (p - 1);
    case (f.kind)
      K_ZERO: return sbit;
      K_INF:  return sbit | infbits;
      K_NAN:  return sbit | infbits | (64'd1 << (p - 2)) |
                     (((f.sig & PAY) >> (64 - p)) & lowmask(p - 1));
      default: ;
    endcase
    if (f.e > bias) return sbit | infbits;
    if (f.e >= emin) begin
      // a mantissa carry rolls into the exponent field
      mant = rne_shift(f.sig, 64 - p);
      return sbit | ((64'(f.e + bias - 1) << (p - 1)) + mant);
    end
    return sbit | rne_shift(f.sig, (64 - p) + (emin - f.e));
  endfunction

  function automatic void pack_ext(input ufloat_t f, output logic [63:0] lo,
                                   output logic [15:0] hi);
    logic [15:0] s;
    s = f.neg ? 16'h8000 : 16'h0000;
    case (f.kind)
      K_ZERO: begin lo = '0; hi = s; end
      K_INF:  begin lo = TOP; hi = s | 16'h7FFF; end
      K_NAN:  begin lo = TOP | 64'h4000_0000_0000_0000 | (f.sig & PAY); hi = s | 16'h7FFF; end
      default: begin lo = f.sig; hi = s | 16'(f.e + 16383) & 16'h7FFF; end
    endcase
  endfunction

  function automatic logic [63:0] trunc_to_int(input ufloat_t f, input int c,
                                               inout status_t st);
    logic [63:0] m, pos_max, neg_lim, neg_bound, mag;
    logic sgn, big;
    sgn = (c <= C_LLONG);
    m = lowmask(int_bits(c));
    pos_max = sgn ? (m >> 1) : m;
    neg_lim = sgn ? ((m >> 1) + 64'd1) : 64'd0;
    neg_bound = (64'd0 - neg_lim) & m;
    if (f.kind == K_NAN) begin
      st = ST_SAT;
      return '0;
    end
    if (f.kind == K_ZERO) return '0;
    big = (f.kind == K_INF) || f.e >= 64;
    mag = '0;
    if (!big && f.e >= 0) mag = f.sig >> (63 - f.e);
    if (f.neg) begin
      if (big || mag > neg_lim) begin
        st = ST_SAT;
        return neg_bound;
      end
      return (64'd0 - mag) & m;
    end
    if (big || mag > pos_max) begin
      st = ST_SAT;
      return pos_max;
    end
    return mag;
  endfunction

  function automatic conv_res_t convert(input conv_req_t q);
    conv_res_t r;
    ufloat_t f;
    int s, d, w, lz;
    logic [63:0] raw, mag;
    logic neg;
    s = canon(q.src);
    d = canon(q.dst);
    r.lo = '0;
    r.hi = '0;
    r.status = ST_OK;
    if (s < 0 || d < 0) begin
      r.status = ST_VOID;
    end else if (s == C_NULL) begin
      if (d == C_NULL) r.lo = q.lo;
      else if (d != C_BOOL) r.status = ST_NULL_DST;
    end else if (d == C_NULL) begin
      if (s >= C_FLT) r.status = ST_FLT_NULL;
      else begin
        raw = (s == C_BOOL) ? (q.lo & 64'hFF) : (q.lo & lowmask(int_bits(s)));
        if (raw != 0) r.status = ST_NZ_NULL;
      end
    end else if (s == d && s >= C_FLT) begin
      r.lo = (s == C_FLT) ? (q.lo & 64'hFFFF_FFFF) : q.lo;
      if (s == C_EXT) r.hi = q.hi;
    end else if (s <= C_BOOL) begin
      neg = 1'b0;
      if (s == C_BOOL) begin
        mag = ((q.lo & 64'hFF) != 0) ? 64'd1 : 64'd0;
      end else begin
        w = int_bits(s);
        raw = q.lo & lowmask(w);
        neg = (s <= C_LLONG) && raw[w - 1];
        mag = neg ? ((64'd0 - raw) & lowmask(w)) : raw;
      end
      if (d == C_BOOL) begin
        r.lo = (mag != 0) ? 64'd1 : 64'd0;
      end else if (d <= C_ULLONG) begin
        r.lo = (neg ? (64'd0 - mag) : mag) & lowmask(int_bits(d));
      end else begin
        f.neg = neg;
        f.kind = (mag != 0) ? K_FIN : K_ZERO;
        f.e = 0;
        f.sig = '0;
        if (mag != 0) begin
          lz = lzc(mag);
          f.sig = mag << lz;
          f.e = 63 - lz;
        end
        if (d == C_FLT) r.lo = pack_ieee(f, 24, 8);
        else if (d == C_DBL) r.lo = pack_ieee(f, 53, 11);
        else pack_ext(f, r.lo, r.hi);
      end
    end else begin
      f = unpack_float(s, q.lo, q.hi);
      if (d == C_BOOL) r.lo = (f.kind != K_ZERO) ? 64'd1 : 64'd0;
      else if (d <= C_ULLONG) r.lo = trunc_to_int(f, d, r.status);
      else if (d == C_FLT) r.lo = pack_ieee(f, 24, 8);
      else if (d == C_DBL) r.lo = pack_ieee(f, 53, 11);
      else pack_ext(f, r.lo, r.hi);
    end
    if (r.status inside {ST_VOID, ST_NULL_DST, ST_NZ_NULL, ST_FLT_NULL}) begin
      r.lo = '0;
      r.hi = '0;
    end
    return r;
  endfunction

  // ------------------------------------------------------------- stimulus --
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_conv(input logic [4:0] src, input logic [4:0] dst,
                          input logic [63:0] lo, input logic [15:0] hi);
    conv_req_t q;
    q.src = src;
    q.dst = dst;
    q.lo = lo;
    q.hi = hi;
    pending_q.push_back(q);
  endtask

  function automatic logic [4:0] rand_code();
    return ($urandom_range(99) < 5) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18, 0));
  endfunction

  // value shaped to the source type so edge cases show up often
  task automatic rand_value(input logic [4:0] src, input logic [4:0] dst,
                            output logic [63:0] lo, output logic [15:0] hi);
    int c, fb, eb, bias, k;
    logic [63:0] frac, ex;
    c = canon(src);
    lo = rand64();
    hi = 16'($urandom);
    k = $urandom_range(99);
    if (c == C_EXT) begin
      if (k < 10) hi[14:0] = 15'h0;
      else if (k < 25) hi[14:0] = 15'h7FFF;
      else if (k < 80) hi[14:0] = 15'(16383 + $urandom_range(140) - 70);
      if ($urandom_range(99) < 85) lo[63] = 1'b1;
      if ($urandom_range(99) < 20) lo[62:0] = '0;
      if ($urandom_range(99) < 15) lo[39:0] = 40'h80_0000_0000;
    end else if (c == C_FLT || c == C_DBL) begin
      fb   = (c == C_FLT) ? 23 : 52;
      eb   = (c == C_FLT) ? 8 : 11;
      bias = (c == C_FLT) ? 127 : 1023;
      frac = lo & lowmask(fb);
      if (k < 10) ex = 0;
      else if (k < 22) ex = lowmask(eb);
      else if (k < 55) ex = 64'(bias + $urandom_range(70) - 3);
      else if (k < 80 && c == C_DBL) ex = 64'(bias + $urandom_range(320) - 160);
      else ex = 64'($urandom) & lowmask(eb);
      if ($urandom_range(99) < 15) frac = '0;
      else if ($urandom_range(99) < 15 && c == C_DBL) frac = (frac & ~lowmask(29)) | (64'd1 << 28);
      lo = (64'($urandom_range(1)) << (fb + eb)) | (ex << fb) | frac;
      if (c == C_FLT) lo[63:32] = $urandom;
    end else begin
      if (k < 15) lo = '0;
      else if (k < 25) lo = lowmask(int_bits(c < 0 ? C_LLONG : c)) ^ 64'($urandom_range(1));
      else if (k < 45) lo = 64'($urandom_range(300)) - 64'd150;
      if (canon(dst) == C_NULL && $urandom_range(1)) lo = '0;
    end
  endtask

  task automatic build_stimulus();
    logic [4:0] s, d;
    logic [63:0] lo;
    logic [15:0] hi;
    // integer extremes, narrowing, widening
    add_conv(5'(C_LLONG), 5'(C_SCHAR), 64'h8000_0000_0000_0080, 16'hFFFF);
    add_conv(5'(C_SCHAR), 5'(C_ULLONG), 64'h0000_0000_0000_0080, 16'h0);
    add_conv(5'(C_UINT), 5'(C_INT), 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
    add_conv(5'(C_BOOL), 5'(C_INT), 64'hFF00, 16'h0);
    add_conv(5'(C_LLONG), 5'(C_BOOL), 64'h8000_0000_0000_0000, 16'h0);
    // integer to float with rounding, ties to even
    add_conv(5'(C_ULLONG), 5'(C_FLT), 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
    add_conv(5'(C_LLONG), 5'(C_DBL), 64'h8000_0000_0000_0000, 16'h0);
    add_conv(5'(C_INT), 5'(C_FLT), 64'h0000_0000_0100_0001, 16'h0);
    add_conv(5'(C_ULLONG), 5'(C_EXT), 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
    // float to integer: saturation, NaN, negative to unsigned
    add_conv(5'(C_DBL), 5'(C_INT), 64'h41E0_0000_0000_0000, 16'h0);
    add_conv(5'(C_DBL), 5'(C_UINT), 64'hBFF0_0000_0000_0000, 16'h0);
    add_conv(5'(C_FLT), 5'(C_LLONG), 64'h0000_0000_7FC0_0001, 16'h0);
    add_conv(5'(C_EXT), 5'(C_LLONG), 64'h8000_0000_0000_0000, 16'hC03E);
    add_conv(5'(C_DBL), 5'(C_SCHAR), 64'hFFF0_0000_0000_0000, 16'h0);
    // float narrowing: overflow, gradual underflow, NaN payload
    add_conv(5'(C_DBL), 5'(C_FLT), 64'h47F0_0000_0000_0000, 16'h0);
    add_conv(5'(C_DBL), 5'(C_FLT), 64'h3690_0000_0000_0001, 16'h0);
    add_conv(5'(C_DBL), 5'(C_FLT), 64'hFFF8_1234_5678_9ABC, 16'h0);
    add_conv(5'(C_EXT), 5'(C_DBL), 64'h0000_0000_0000_0001, 16'h0000);
    // invalid extended encodings: unnormal, pseudo-infinity, pseudo-denormal
    add_conv(5'(C_EXT), 5'(C_DBL), 64'h4000_0000_0000_0000, 16'h8123);
    add_conv(5'(C_EXT), 5'(C_FLT), 64'h0000_0000_0000_0000, 16'h7FFF);
    add_conv(5'(C_EXT), 5'(C_DBL), 64'h8000_0000_0000_0000, 16'h0000);
    // same-format passthrough, nullptr and void rules
    add_conv(5'(C_EXT), 5'(C_EXT), 64'h1234_5678_9ABC_DEF0, 16'h7FFF);
    add_conv(T_NULL, T_NULL, 64'hDEAD_BEEF_0000_0001, 16'h0);
    add_conv(T_NULL, 5'(C_BOOL), 64'h5, 16'h0);
    add_conv(T_NULL, T_CHAR32, 64'h0, 16'h0);
    add_conv(T_CHAR16, T_NULL, 64'h1_0000, 16'h0);
    add_conv(T_WCHAR, T_NULL, 64'h1, 16'h0);
    add_conv(5'(C_DBL), T_NULL, 64'h0, 16'h0);
    add_conv(T_VOID, 5'(C_INT), 64'h1, 16'h0);
    add_conv(5'(C_INT), 5'd31, 64'h1, 16'h0);
    repeat (750) begin
      s = rand_code();
      d = rand_code();
      rand_value(s, d, lo, hi);
      add_conv(s, d, lo, hi);
    end
  endtask

  // --------------------------------------------------------------- phases --
  // no idling / sender idle / receiver stalling / both / no idling
  always_comb begin
    phase = (n_items == 0) ? 0 : (sent * 5) / n_items;
    case (phase)
      1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
      3:       begin send_idle_pct = 14; recv_stall_pct = 14; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  end

  // --------------------------------------------------------------- driver --
  always @(posedge clk) begin
    conv_req_t q;
    logic take;
    take = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (take) begin
        expected_q.push_back(convert('{in_source_type, in_dest_type,
                                       in_value_low, in_value_high}));
        sent <= sent + 1;
      end
      // payload is held while stalled; a new one is only loaded after a take or while idle
      if (!in_valid || take) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          q = pending_q.pop_front();
          in_valid <= 1'b1;
          in_source_type <= q.src;
          in_dest_type <= q.dst;
          in_value_low <= q.lo;
          in_value_high <= q.hi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- monitor --
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    conv_res_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_result_low, 64'd0);
      end else begin
        r = expected_q.pop_front();
        if (out_result_low !== r.lo) report_mismatch("result_low", out_result_low, r.lo);
        if (out_result_high !== r.hi)
          report_mismatch("result_high", 64'(out_result_high), 64'(r.hi));
        if (out_status !== r.status)
          report_mismatch("status", 64'(out_status), 64'(r.status));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // ------------------------------------------------------------- watchdog --
  // counts cycles in which neither channel completes a transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------------- main --
  initial begin
    build_stimulus();
    n_items = pending_q.size();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    // wait out the tail so any stray transaction gets caught
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
